>>> sv/mta_pkg.sv
// Shared types, constants and the tanh segment table for the perceptron move chooser.
package mta_pkg;

  // Network shape and weight store layout.
  localparam int HIDDEN       = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int NUM_IN       = 5;
  localparam int NUM_OUT      = 3;
  localparam int B1_BASE      = NUM_IN * HIDDEN;
  localparam int W2_BASE      = B1_BASE + HIDDEN;
  localparam int B2_BASE      = W2_BASE + HIDDEN * NUM_OUT;
  localparam int STORE_DEPTH  = B2_BASE + NUM_OUT;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int WIDX_W  = 8;
  localparam int WVAL_W  = 16;
  localparam int POS_W   = 10;
  localparam int SPD_W   = 8;
  localparam int FIELD_W = 10;
  localparam int MOVE_W  = 2;

  // Fixed-point formats.
  localparam int FRAC_W   = 12;
  localparam int ONE_Q12  = 4096;
  localparam int SPEED_DIV = 10;
  localparam int NUM_W    = POS_W + FRAC_W;
  localparam int X_W      = NUM_W + 1;
  localparam int TANH_W   = 13;
  localparam int H_W      = 14;
  localparam int PROD_W   = X_W + WEIGHT_WIDTH;
  localparam int ACC_W    = PROD_W + 3;

  // Sequencing counters.
  localparam int SRC_N   = (HIDDEN > NUM_IN) ? HIDDEN : NUM_IN;
  localparam int SRC_W   = $clog2(SRC_N);
  localparam int TERM_W  = $clog2(SRC_N + 1);
  localparam int X_IDX_W = $clog2(NUM_IN);
  localparam int H_IDX_W = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;

  // Tanh segments.
  localparam int SEG_SHIFT = 20;
  localparam int SEG_LIMIT = 64;
  localparam int SEG_W     = $clog2(SEG_LIMIT) + 1;
  localparam logic [63:0] EXP_STEP_Q20 = 64'd1116203;
  localparam logic [63:0] ONE_Q20      = 64'd1048576;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_INFER = 1'b1;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH  = 1'b1;
  localparam logic [FIELD_W-1:0] FIELD_HEIGHT_RST = 10'd480;
  localparam logic [FIELD_W-1:0] FIELD_WIDTH_RST  = 10'd640;

  // Normalized input slots.
  localparam logic [X_IDX_W-1:0] X_BALL_ROW   = 3'd0;
  localparam logic [X_IDX_W-1:0] X_BALL_COL   = 3'd1;
  localparam logic [X_IDX_W-1:0] X_ROW_SPEED  = 3'd2;
  localparam logic [X_IDX_W-1:0] X_COL_SPEED  = 3'd3;
  localparam logic [X_IDX_W-1:0] X_PADDLE_ROW = 3'd4;

  // Layer codes.
  localparam logic LAYER_HID = 1'b0;
  localparam logic LAYER_OUT = 1'b1;

  typedef logic [SEG_LIMIT-1:0][TANH_W-1:0] tanh_tab_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              bias;
    logic [SRC_W-1:0]  src;
    logic              first;
    logic              last;
    logic              layer;
    logic [SRC_W-1:0]  dst;
  } mac_cmd_t;

  typedef struct packed {
    logic               take;
    logic               wr_en;
    logic               norm_start;
    logic [X_IDX_W-1:0] norm_idx;
    mac_cmd_t           mac;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       res_done;
    logic [1:0] best_k;
  } dp_sts_t;

  // Segment m holds round(4096*tanh((m+0.5)/16)); e^(2m+1)/16 is built by truncating
  // Q.20 products and the quotient is found by shift-and-subtract.
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t   tab;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [12:0] q;
    int          m;
    int          b;
    e = (ONE_Q20 * EXP_STEP_Q20) >> 20;
    for (m = 0; m < SEG_LIMIT; m++) begin
      num = (e - ONE_Q20) << FRAC_W;
      den = e + ONE_Q20;
      rem = num + (den >> 1);
      q = '0;
      for (b = 12; b >= 0; b--) begin
        if (rem >= (den << b)) begin
          rem = rem - (den << b);
          q[b] = 1'b1;
        end
      end
      tab[m] = q;
      e = (e * EXP_STEP_Q20) >> 20;
      e = (e * EXP_STEP_Q20) >> 20;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

>>> sv/mta_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface mta_in_if;
  import mta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [WIDX_W-1:0]        weight_index;
  logic signed [WVAL_W-1:0] weight_value;
  logic [POS_W-1:0]         ball_row;
  logic [POS_W-1:0]         ball_col;
  logic signed [SPD_W-1:0]  ball_row_speed;
  logic signed [SPD_W-1:0]  ball_col_speed;
  logic [POS_W-1:0]         paddle_row;

  modport source (output valid, operation, weight_index, weight_value, ball_row, ball_col,
                  ball_row_speed, ball_col_speed, paddle_row, input ready);
  modport sink (input valid, operation, weight_index, weight_value, ball_row, ball_col,
                ball_row_speed, ball_col_speed, paddle_row, output ready);
endinterface

interface mta_out_if;
  import mta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MOVE_W-1:0] move;
  logic                     is_decision;

  modport source (output valid, move, is_decision, input ready);
  modport sink (input valid, move, is_decision, output ready);
endinterface

>>> sv/mlp_tanh_argmax_inference.sv
// Top level of the two-layer perceptron move chooser.
//
//   Channel   Direction  Handshake        Carries
//   in_ch     sink       valid/ready      weight write or inference request
//   out_ch    source     valid/ready      move and is_decision, one per request
//   cfg_*     input      cfg_we strobe    field_height (index 0), field_width (index 1)
//
// A weight write is acknowledged in the result register; while that register holds an
// unaccepted result, the acknowledge waits in S_ACK. An inference runs five normalizations
// on the shared one-bit-per-cycle divider, then issues 147 products one per cycle from the
// single weight memory read port into the one multiply-accumulate pipeline, then drains it.
// Reset is synchronous and active low; the weight memory has no reset and needs no sweep.
// A result waiting on out_ch does not block a new request; only the next result waits.
module mlp_tanh_argmax_inference (
  input  logic                            clk,
  input  logic                            rst_n,
  mta_in_if.sink                          in_ch,
  mta_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mta_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mta_pkg::FIELD_W-1:0]     cfg_data
);
  import mta_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mta_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_operation    (in_ch.operation),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_move        (out_ch.move),
    .out_is_decision (out_ch.is_decision),
    .out_ready       (out_ch.ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  mta_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_weight_index   (in_ch.weight_index),
    .in_weight_value   (in_ch.weight_value),
    .in_ball_row       (in_ch.ball_row),
    .in_ball_col       (in_ch.ball_col),
    .in_ball_row_speed (in_ch.ball_row_speed),
    .in_ball_col_speed (in_ch.ball_col_speed),
    .in_paddle_row     (in_ch.paddle_row),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

endmodule

>>> sv/mta_div.sv
// Restoring divider, one quotient bit per cycle, for input normalization.
module mta_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mta_pkg::NUM_W-1:0]     num,
  input  logic [mta_pkg::FIELD_W-1:0]   den,
  output logic                          done,
  output logic [mta_pkg::NUM_W-1:0]     quot
);
  import mta_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [FIELD_W-1:0] rem_r;
  logic [FIELD_W-1:0] den_r;
  logic [NUM_W-1:0]   quot_r;
  logic [FIELD_W:0]   shifted;
  logic               ge;
  logic [FIELD_W-1:0] rem_nxt;

  assign shifted = {rem_r, quot_r[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign rem_nxt = ge ? FIELD_W'(shifted - {1'b0, den_r}) : shifted[FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W - 1);
        rem_r  <= '0;
        den_r  <= den;
        quot_r <= num;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[NUM_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> sv/mta_datapath.sv
// Datapath: request latch, normalization, weight memory, MAC pipeline, tanh and argmax.
module mta_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mta_pkg::dp_cmd_t                 cmd,
  output mta_pkg::dp_sts_t                 sts,
  input  logic [mta_pkg::WIDX_W-1:0]       in_weight_index,
  input  logic signed [mta_pkg::WVAL_W-1:0] in_weight_value,
  input  logic [mta_pkg::POS_W-1:0]        in_ball_row,
  input  logic [mta_pkg::POS_W-1:0]        in_ball_col,
  input  logic signed [mta_pkg::SPD_W-1:0] in_ball_row_speed,
  input  logic signed [mta_pkg::SPD_W-1:0] in_ball_col_speed,
  input  logic [mta_pkg::POS_W-1:0]        in_paddle_row,
  input  logic                             cfg_we,
  input  logic [mta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mta_pkg::FIELD_W-1:0]      cfg_data
);
  import mta_pkg::*;

  localparam logic signed [ACC_W-1:0] SEG_HI = ACC_W'(SEG_LIMIT * (2 ** SEG_SHIFT));
  localparam logic signed [ACC_W-1:0] SEG_LO = -SEG_HI;
  localparam logic signed [H_W-1:0]   H_POS  = H_W'(ONE_Q12);
  localparam logic signed [H_W-1:0]   H_NEG  = -H_POS;

  // Configuration.
  logic [FIELD_W-1:0] field_height_r;
  logic [FIELD_W-1:0] field_width_r;

  // Latched request.
  logic [WIDX_W-1:0]              widx_r;
  logic signed [WEIGHT_WIDTH-1:0] wval_r;
  logic [POS_W-1:0]               brow_r;
  logic [POS_W-1:0]               bcol_r;
  logic [POS_W-1:0]               prow_r;
  logic signed [SPD_W-1:0]        rspd_r;
  logic signed [SPD_W-1:0]        cspd_r;

  // Normalization.
  logic [FIELD_W-1:0]      fh_eff;
  logic [FIELD_W-1:0]      fw_eff;
  logic [FIELD_W-1:0]      div_den;
  logic [NUM_W-1:0]        div_num;
  logic [POS_W-1:0]        pos_sel;
  logic signed [SPD_W-1:0] spd_sel;
  logic                    is_speed;
  logic signed [SPD_W:0]   spd_ext;
  logic [SPD_W:0]          spd_mag;
  logic                    div_done;
  logic [NUM_W-1:0]        div_quot;
  logic                    neg_r;
  logic [X_IDX_W-1:0]      xidx_r;
  logic signed [X_W-1:0]   x_r [NUM_IN];
  logic signed [X_W-1:0]   quot_s;

  // Weight memory and MAC pipeline.
  logic signed [WEIGHT_WIDTH-1:0] mem [STORE_DEPTH];
  logic signed [WEIGHT_WIDTH-1:0] rdata_r;
  mac_cmd_t                       c1_r;
  mac_cmd_t                       c2_r;
  mac_cmd_t                       c3_r;
  logic signed [X_W-1:0]          opnd;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [H_W-1:0]          h_r [HIDDEN];

  // Activation and decision.
  logic [SEG_W-1:0]        seg;
  logic [SEG_W-2:0]        seg_m;
  logic [TANH_W-1:0]       tanh_mag;
  logic signed [H_W-1:0]   h_val;
  logic signed [ACC_W-1:0] best_r;
  logic [1:0]              best_k_r;
  logic                    res_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_height_r <= FIELD_HEIGHT_RST;
      field_width_r  <= FIELD_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIELD_HEIGHT) begin
        field_height_r <= cfg_data;
      end
      if (cfg_index == CFG_FIELD_WIDTH) begin
        field_width_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      widx_r <= in_weight_index;
      wval_r <= WEIGHT_WIDTH'(in_weight_value);
      brow_r <= in_ball_row;
      bcol_r <= in_ball_col;
      prow_r <= in_paddle_row;
      rspd_r <= in_ball_row_speed;
      cspd_r <= in_ball_col_speed;
    end
  end

  // A field size of zero divides as one.
  assign fh_eff = (field_height_r == '0) ? FIELD_W'(1) : field_height_r;
  assign fw_eff = (field_width_r == '0) ? FIELD_W'(1) : field_width_r;

  always_comb begin
    pos_sel  = brow_r;
    spd_sel  = rspd_r;
    div_den  = fh_eff;
    is_speed = 1'b0;
    unique case (cmd.norm_idx)
      X_BALL_ROW: begin
        pos_sel = brow_r;
        div_den = fh_eff;
      end
      X_BALL_COL: begin
        pos_sel = bcol_r;
        div_den = fw_eff;
      end
      X_ROW_SPEED: begin
        spd_sel  = rspd_r;
        div_den  = FIELD_W'(SPEED_DIV);
        is_speed = 1'b1;
      end
      X_COL_SPEED: begin
        spd_sel  = cspd_r;
        div_den  = FIELD_W'(SPEED_DIV);
        is_speed = 1'b1;
      end
      X_PADDLE_ROW: begin
        pos_sel = prow_r;
        div_den = fh_eff;
      end
      default: begin
        pos_sel = brow_r;
        div_den = fh_eff;
      end
    endcase
  end

  assign spd_ext = (SPD_W + 1)'(spd_sel);
  assign spd_mag = spd_sel[SPD_W-1] ? (SPD_W + 1)'(-spd_ext) : (SPD_W + 1)'(spd_ext);

  // Rounding to nearest: add half the divisor before the truncating divide.
  assign div_num = is_speed ? NUM_W'({spd_mag, FRAC_W'(0)}) + NUM_W'(SPEED_DIV / 2)
                            : NUM_W'({pos_sel, FRAC_W'(0)}) + NUM_W'(div_den >> 1);

  mta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.norm_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign quot_s = $signed({1'b0, div_quot});

  always_ff @(posedge clk) begin
    if (cmd.norm_start) begin
      neg_r  <= is_speed && spd_sel[SPD_W-1];
      xidx_r <= cmd.norm_idx;
    end
    if (div_done) begin
      x_r[xidx_r] <= neg_r ? -quot_s : quot_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (int'(widx_r) < STORE_DEPTH)) begin
      mem[widx_r[ADDR_W-1:0]] <= wval_r;
    end
    if (cmd.mac.valid) begin
      rdata_r <= mem[cmd.mac.addr];
    end
  end

  // Bias terms multiply by one in Q.12 so they land in the Q.24 sum.
  always_comb begin
    if (c1_r.bias) begin
      opnd = X_W'(ONE_Q12);
    end else if (c1_r.layer == LAYER_HID) begin
      opnd = x_r[c1_r.src[X_IDX_W-1:0]];
    end else begin
      opnd = X_W'(h_r[c1_r.src[H_IDX_W-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
    end else begin
      c1_r <= cmd.mac;
      c2_r <= c1_r;
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c1_r.valid) begin
      prod_r <= rdata_r * opnd;
    end
    if (c2_r.valid) begin
      acc_r <= c2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  assign seg      = acc_r[SEG_SHIFT+SEG_W-1:SEG_SHIFT];
  assign seg_m    = seg[SEG_W-1] ? ~seg[SEG_W-2:0] : seg[SEG_W-2:0];
  assign tanh_mag = TANH_TAB[seg_m];

  always_comb begin
    if (acc_r < SEG_LO) begin
      h_val = H_NEG;
    end else if (acc_r >= SEG_HI) begin
      h_val = H_POS;
    end else if (seg[SEG_W-1]) begin
      h_val = -$signed({1'b0, tanh_mag});
    end else begin
      h_val = $signed({1'b0, tanh_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (c3_r.valid && c3_r.last && (c3_r.layer == LAYER_HID)) begin
      h_r[c3_r.dst[H_IDX_W-1:0]] <= h_val;
    end
    // Strict compare keeps the first of equal maxima.
    if (c3_r.valid && c3_r.last && (c3_r.layer == LAYER_OUT)) begin
      if ((c3_r.dst == '0) || (acc_r > best_r)) begin
        best_r   <= acc_r;
        best_k_r <= c3_r.dst[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_done_r <= 1'b0;
    end else begin
      res_done_r <= c3_r.valid && c3_r.last && (c3_r.layer == LAYER_OUT) &&
                    (c3_r.dst == SRC_W'(NUM_OUT - 1));
    end
  end

  assign sts.div_done = div_done;
  assign sts.res_done = res_done_r;
  assign sts.best_k   = best_k_r;

endmodule

>>> sv/mta_ctrl.sv
// Controller: request handshake, normalization sequencing, MAC issue and result register.
module mta_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_operation,
  output logic                            in_ready,
  output logic                            out_valid,
  output logic signed [mta_pkg::MOVE_W-1:0] out_move,
  output logic                            out_is_decision,
  input  logic                            out_ready,
  input  mta_pkg::dp_sts_t                sts,
  output mta_pkg::dp_cmd_t                cmd
);
  import mta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_NORM_WAIT,
    S_MAC,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                   state_r;
  logic                     out_valid_r;
  logic signed [MOVE_W-1:0] out_move_r;
  logic                     out_dec_r;
  logic                     wr_en_r;
  logic                     norm_start_r;
  logic [X_IDX_W-1:0]       norm_idx_r;
  mac_cmd_t                 mac_r;
  logic                     layer_r;
  logic [SRC_W-1:0]         neur_r;
  logic [TERM_W-1:0]        term_r;
  logic [ADDR_W-1:0]        addr_r;

  logic                     take;
  logic                     slot_free;
  logic [TERM_W-1:0]        last_term;
  logic [SRC_W-1:0]         last_neur;
  logic [ADDR_W-1:0]        bias_base;
  logic [ADDR_W-1:0]        wgt_base;
  logic [ADDR_W-1:0]        stride;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign last_term = (layer_r == LAYER_HID) ? TERM_W'(NUM_IN) : TERM_W'(HIDDEN);
  assign last_neur = (layer_r == LAYER_HID) ? SRC_W'(HIDDEN - 1) : SRC_W'(NUM_OUT - 1);
  assign bias_base = (layer_r == LAYER_HID) ? ADDR_W'(B1_BASE) : ADDR_W'(B2_BASE);
  assign wgt_base  = (layer_r == LAYER_HID) ? ADDR_W'(0) : ADDR_W'(W2_BASE);
  assign stride    = (layer_r == LAYER_HID) ? ADDR_W'(HIDDEN) : ADDR_W'(NUM_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      wr_en_r      <= 1'b0;
      norm_start_r <= 1'b0;
      norm_idx_r   <= X_BALL_ROW;
      mac_r        <= '0;
      layer_r      <= LAYER_HID;
      neur_r       <= '0;
      term_r       <= '0;
      addr_r       <= '0;
    end else begin
      wr_en_r      <= 1'b0;
      norm_start_r <= 1'b0;
      mac_r.valid  <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (in_operation == OP_WRITE) begin
              wr_en_r <= 1'b1;
              if (slot_free) begin
                out_valid_r <= 1'b1;
                out_move_r  <= '0;
                out_dec_r   <= 1'b0;
              end else begin
                state_r <= S_ACK;
              end
            end else begin
              norm_idx_r   <= X_BALL_ROW;
              norm_start_r <= 1'b1;
              state_r      <= S_NORM_WAIT;
            end
          end
        end
        S_ACK: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_move_r  <= '0;
            out_dec_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_NORM_WAIT: begin
          if (sts.div_done) begin
            if (norm_idx_r == X_IDX_W'(NUM_IN - 1)) begin
              layer_r <= LAYER_HID;
              neur_r  <= '0;
              term_r  <= '0;
              addr_r  <= ADDR_W'(B1_BASE);
              state_r <= S_MAC;
            end else begin
              norm_idx_r   <= norm_idx_r + X_IDX_W'(1);
              norm_start_r <= 1'b1;
            end
          end
        end
        S_MAC: begin
          // Term zero is the bias; the rest walk one weight column or row.
          mac_r.valid <= 1'b1;
          mac_r.addr  <= addr_r;
          mac_r.bias  <= (term_r == '0);
          mac_r.src   <= SRC_W'(term_r - TERM_W'(1));
          mac_r.first <= (term_r == '0);
          mac_r.last  <= (term_r == last_term);
          mac_r.layer <= layer_r;
          mac_r.dst   <= neur_r;
          if (term_r == last_term) begin
            term_r <= '0;
            if (neur_r == last_neur) begin
              if (layer_r == LAYER_OUT) begin
                state_r <= S_DRAIN;
              end else begin
                layer_r <= LAYER_OUT;
                neur_r  <= '0;
                addr_r  <= ADDR_W'(B2_BASE);
              end
            end else begin
              neur_r <= neur_r + SRC_W'(1);
              addr_r <= bias_base + ADDR_W'(neur_r) + ADDR_W'(1);
            end
          end else begin
            term_r <= term_r + TERM_W'(1);
            addr_r <= (term_r == '0) ? wgt_base + ADDR_W'(neur_r) : addr_r + stride;
          end
        end
        S_DRAIN: begin
          if (sts.res_done) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_move_r  <= $signed(MOVE_W'(sts.best_k) - MOVE_W'(1));
            out_dec_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_move        = out_move_r;
  assign out_is_decision = out_dec_r;

  assign cmd.take       = take;
  assign cmd.wr_en      = wr_en_r;
  assign cmd.norm_start = norm_start_r;
  assign cmd.norm_idx   = norm_idx_r;
  assign cmd.mac        = mac_r;

  a_mac_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_r.valid |-> $past(state_r) == S_MAC)
    else $error("MAC command issued outside the MAC phase");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_NORM_WAIT)
    else $error("Divider finished while no normalization was pending");

  a_res_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.res_done |-> state_r == S_DRAIN)
    else $error("Decision finished outside the drain phase");

  a_infer_start: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_operation == OP_INFER) |=> (state_r == S_NORM_WAIT && norm_start_r))
    else $error("Inference request did not start normalization");

endmodule
